// ----- hdl/mpbe_pkg.sv -----
// shared types and constants of the multipart body extractor
`timescale 1ns / 1ps
`default_nettype none
package mpbe_pkg;

	localparam int BYTE_W   = 8;
	localparam int CFG_W    = 7;
	localparam int IDX_W    = 7;
	localparam int TOTAL_W  = 32;

	localparam logic [CFG_W-1:0] LEN_RESET = 7'd4;
	localparam logic [31:0]      SEP_WORD  = 32'h0D0A_0D0A;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_DATA  = 2'd2
	} item_kind_t;

	typedef enum logic [1:0] {
		ST_SUCCESS    = 2'd0,
		ST_OVERFLOW   = 2'd1,
		ST_NO_PAYLOAD = 2'd2
	} finish_status_t;

	typedef enum logic {
		RK_PAYLOAD = 1'b0,
		RK_FINISH  = 1'b1
	} result_kind_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POPRD,
		S_POPOUT,
		S_CMP,
		S_CMPEND,
		S_FINOUT
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic pop_latch;
		logic emit_pop;
		logic cmp_issue;
		logic cmp_done;
		logic emit_fin;
	} ctl_cmd_t;

	typedef struct packed {
		logic   is_data;
		phase_t phase;
		logic   sep_hit;
		logic   cap_hit;
		logic   last;
		logic   pop_need;
		logic   cmp_able;
		logic   cmp_able_q;
		logic   last_q;
		logic   cmp_last;
		logic   match;
		logic   out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/mpbe_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module mpbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 96
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/mpbe_ctrl.sv -----
// controller state machine of the multipart body extractor
`timescale 1ns / 1ps
`default_nettype none
module mpbe_ctrl import mpbe_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t status,
	output ctl_cmd_t        cmd
);

	ctl_state_t state_q;
	ctl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && status.is_data) begin
					if (status.phase == PH_HEADER) begin
						if (status.sep_hit ? status.last : (status.cap_hit || status.last)) begin
							state_next = S_FINOUT;
						end
					end else if (status.phase == PH_PAYLOAD) begin
						if (status.pop_need) begin
							state_next = S_POPRD;
						end else if (status.cmp_able) begin
							state_next = S_CMP;
						end else if (status.last) begin
							state_next = S_FINOUT;
						end
					end
				end
			end
			S_POPRD: begin
				state_next = S_POPOUT;
			end
			S_POPOUT: begin
				if (status.out_free) begin
					if (status.cmp_able_q) begin
						state_next = S_CMP;
					end else if (status.last_q) begin
						state_next = S_FINOUT;
					end else begin
						state_next = S_IDLE;
					end
				end
			end
			S_CMP: begin
				if (status.cmp_last) begin
					state_next = S_CMPEND;
				end
			end
			S_CMPEND: begin
				if (status.match || status.last_q) begin
					state_next = S_FINOUT;
				end else begin
					state_next = S_IDLE;
				end
			end
			S_FINOUT: begin
				if (status.out_free) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_POPRD: begin
				cmd.pop_latch = 1'b1;
			end
			S_POPOUT: begin
				cmd.emit_pop = status.out_free;
			end
			S_CMP: begin
				cmd.cmp_issue = 1'b1;
			end
			S_CMPEND: begin
				cmd.cmp_done = 1'b1;
			end
			S_FINOUT: begin
				cmd.emit_fin = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/mpbe_dp.sv -----
// datapath: window buffer, delimiter table, header scan, counters and result register
`timescale 1ns / 1ps
`default_nettype none
module mpbe_dp import mpbe_pkg::*; #(
	parameter int MAX_DELIMITER = 96,
	parameter int HEADER_CAP    = 512
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         kind,
	input  wire logic [IDX_W-1:0]   table_index,
	input  wire logic [BYTE_W-1:0]  byte_value,
	input  wire logic               last_byte,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CFG_W-1:0]   delimiter_length,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    result_kind,
	output logic [BYTE_W-1:0]       payload_byte,
	output logic [1:0]              finish_status,
	output logic                    delimiter_found,
	output logic [TOTAL_W-1:0]      payload_total,
	input  wire ctl_cmd_t           cmd,
	output dp_status_t              status
);

	localparam int AW = $clog2(MAX_DELIMITER);
	localparam int LW = $clog2(MAX_DELIMITER + 1);
	localparam int SW = LW + 1;
	localparam int CW = (LW > CFG_W) ? LW : CFG_W;
	localparam int HW = $clog2(HEADER_CAP);

	logic [CFG_W-1:0]   len_cfg_q;
	logic [AW-1:0]      head_q;
	logic [LW-1:0]      fill_q;
	logic [31:0]        last4_q;
	logic [HW-1:0]      hcnt_q;
	phase_t             phase_q;
	logic [TOTAL_W-1:0] pcount_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      idx_q;
	logic               last_q;
	logic               cmp_able_q;
	logic               ovf_q;
	logic               found_q;
	logic               mism_q;
	logic               cmp_v_s1;
	logic [BYTE_W-1:0]  pop_byte_q;
	logic               out_valid_q;
	logic               result_kind_q;
	logic [BYTE_W-1:0]  payload_byte_q;
	logic [1:0]         finish_status_q;
	logic               delimiter_found_q;
	logic [TOTAL_W-1:0] payload_total_q;

	logic [LW-1:0]      eff_len;
	logic               pop_need;
	logic [AW-1:0]      head_inc;
	logic [AW-1:0]      head_new;
	logic [LW-1:0]      fill_new;
	logic [SW-1:0]      tail_sum;
	logic [AW-1:0]      tail;
	logic               cmp_able;
	logic [SW-1:0]      base_sum;
	logic [AW-1:0]      base;
	logic [AW-1:0]      ptr_inc;
	logic [31:0]        last4_next;
	logic [HW-1:0]      hcnt_next;
	logic               sep_hit;
	logic               cap_hit;
	logic               is_start;
	logic               is_load;
	logic               is_data;
	logic               idx_ok;
	logic               out_free;
	logic               diff;
	logic               match;
	logic [TOTAL_W-1:0] pcount_inc;
	logic [BYTE_W-1:0]  win_rdata;
	logic [BYTE_W-1:0]  tbl_rdata;
	logic [AW-1:0]      win_raddr;
	logic               win_we;
	logic               tbl_we;
	finish_status_t     fin_status;

	assign cfg_ready = 1'b1;

	// length clamped to 1..MAX_DELIMITER
	always_comb begin
		if (len_cfg_q == '0) begin
			eff_len = LW'(1);
		end else if (CW'(len_cfg_q) > CW'(MAX_DELIMITER)) begin
			eff_len = LW'(MAX_DELIMITER);
		end else begin
			eff_len = LW'(CW'(len_cfg_q));
		end
	end

	assign is_start = (kind == KIND_START);
	assign is_load  = (kind == KIND_LOAD);
	assign is_data  = (kind == KIND_DATA);
	assign idx_ok   = (CW'(table_index) < CW'(MAX_DELIMITER));

	// circular window pointers
	assign pop_need = (fill_q >= eff_len);
	assign head_inc = (head_q == AW'(MAX_DELIMITER - 1)) ? '0 : head_q + AW'(1);
	assign head_new = pop_need ? head_inc : head_q;
	assign fill_new = pop_need ? fill_q : fill_q + LW'(1);
	assign tail_sum = SW'(head_q) + SW'(fill_q);
	assign tail     = (tail_sum >= SW'(MAX_DELIMITER)) ?
		AW'(tail_sum - SW'(MAX_DELIMITER)) : AW'(tail_sum);
	assign cmp_able = (fill_new >= eff_len);
	assign base_sum = SW'(head_new) + SW'(fill_new - eff_len);
	assign base     = (base_sum >= SW'(MAX_DELIMITER)) ?
		AW'(base_sum - SW'(MAX_DELIMITER)) : AW'(base_sum);
	assign ptr_inc  = (ptr_q == AW'(MAX_DELIMITER - 1)) ? '0 : ptr_q + AW'(1);

	// header separator scan
	assign last4_next = {last4_q[23:0], byte_value};
	assign hcnt_next  = hcnt_q + HW'(1);
	assign sep_hit    = (last4_next == SEP_WORD);
	assign cap_hit    = (hcnt_next >= HW'(HEADER_CAP - 1));

	assign diff       = (win_rdata != tbl_rdata);
	assign match      = !(mism_q || (cmp_v_s1 && diff));
	assign out_free   = !out_valid_q || out_ready;
	assign pcount_inc = (pcount_q == '1) ? pcount_q : pcount_q + TOTAL_W'(1);

	always_comb begin
		if (ovf_q) begin
			fin_status = ST_OVERFLOW;
		end else if (pcount_q == '0) begin
			fin_status = ST_NO_PAYLOAD;
		end else begin
			fin_status = ST_SUCCESS;
		end
	end

	assign win_raddr = cmd.cmp_issue ? ptr_q : head_q;
	assign win_we    = cmd.accept && is_data && (phase_q == PH_PAYLOAD);
	assign tbl_we    = cmd.accept && is_load && idx_ok;

	mpbe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_DELIMITER)
	) u_window (
		.clk   (clk),
		.we    (win_we),
		.waddr (tail),
		.wdata (byte_value),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	mpbe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_DELIMITER)
	) u_delim (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(table_index)),
		.wdata (byte_value),
		.raddr (idx_q),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q   <= LEN_RESET;
			head_q      <= '0;
			fill_q      <= '0;
			last4_q     <= '0;
			hcnt_q      <= '0;
			phase_q     <= PH_HEADER;
			pcount_q    <= '0;
			last_q      <= 1'b0;
			cmp_able_q  <= 1'b0;
			ovf_q       <= 1'b0;
			found_q     <= 1'b0;
			mism_q      <= 1'b0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				len_cfg_q <= delimiter_length;
			end
			cmp_v_s1 <= cmd.cmp_issue;
			if (cmp_v_s1 && diff) begin
				mism_q <= 1'b1;
			end
			if (cmd.accept && is_start) begin
				head_q   <= '0;
				fill_q   <= '0;
				last4_q  <= '0;
				hcnt_q   <= '0;
				phase_q  <= PH_HEADER;
				pcount_q <= '0;
			end
			if (cmd.accept && is_data && (phase_q == PH_HEADER)) begin
				last4_q    <= last4_next;
				hcnt_q     <= hcnt_next;
				last_q     <= last_byte;
				cmp_able_q <= 1'b0;
				found_q    <= 1'b0;
				ovf_q      <= !sep_hit && cap_hit;
				if (sep_hit) begin
					phase_q <= PH_PAYLOAD;
				end
			end
			if (win_we) begin
				head_q     <= head_new;
				fill_q     <= fill_new;
				last_q     <= last_byte;
				cmp_able_q <= cmp_able;
				found_q    <= 1'b0;
				ovf_q      <= 1'b0;
				mism_q     <= 1'b0;
			end
			if (cmd.cmp_done) begin
				found_q <= match;
			end
			if (cmd.emit_pop) begin
				pcount_q <= pcount_inc;
			end
			if (cmd.emit_fin) begin
				phase_q <= PH_DONE;
				fill_q  <= '0;
			end
			if (cmd.emit_pop || cmd.emit_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			ptr_q <= base;
			idx_q <= '0;
		end else if (cmd.cmp_issue) begin
			ptr_q <= ptr_inc;
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.pop_latch) begin
			pop_byte_q <= win_rdata;
		end
		if (cmd.emit_pop) begin
			result_kind_q     <= RK_PAYLOAD;
			payload_byte_q    <= pop_byte_q;
			finish_status_q   <= ST_SUCCESS;
			delimiter_found_q <= 1'b0;
			payload_total_q   <= pcount_inc;
		end else if (cmd.emit_fin) begin
			result_kind_q     <= RK_FINISH;
			payload_byte_q    <= '0;
			finish_status_q   <= fin_status;
			delimiter_found_q <= found_q;
			payload_total_q   <= pcount_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = result_kind_q;
	assign payload_byte    = payload_byte_q;
	assign finish_status   = finish_status_q;
	assign delimiter_found = delimiter_found_q;
	assign payload_total   = payload_total_q;

	assign status.is_data    = is_data;
	assign status.phase      = phase_q;
	assign status.sep_hit    = sep_hit;
	assign status.cap_hit    = cap_hit;
	assign status.last       = last_byte;
	assign status.pop_need   = pop_need;
	assign status.cmp_able   = cmp_able;
	assign status.cmp_able_q = cmp_able_q;
	assign status.last_q     = last_q;
	assign status.cmp_last   = (LW'(idx_q) == eff_len - LW'(1));
	assign status.match      = match;
	assign status.out_free   = out_free;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(MAX_DELIMITER))
		else $error("window fill above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(head_q) < SW'(MAX_DELIMITER))
		else $error("window head out of range");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pop || cmd.emit_fin) |-> out_free)
		else $error("result loaded over a waiting transaction");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_fin |=> (phase_q == PH_DONE) && (fill_q == '0))
		else $error("finish did not close the body");

endmodule
`default_nettype wire

// ----- hdl/multipart_part_body_extractor_core.sv -----
// top level of the multipart part body extractor
//
// channel   direction  handshake              contents
// in        input      in_valid / in_ready    kind, table_index, byte_value, last_byte
// out       output     out_valid / out_ready  result_kind, payload_byte, finish_status,
//                                             delimiter_found, payload_total
// cfg       input      cfg_valid / cfg_ready  delimiter_length
//
// start, table load, header and finished-body bytes are taken in S_IDLE, a finish result then in S_FINOUT
// a payload byte is taken in S_IDLE; when the window holds len bytes the oldest pops via
// S_POPRD and S_POPOUT, then S_CMP compares one window byte with one table byte per cycle,
// S_CMPEND ends the compare; the single read port of each ram sets the compare length
// asynchronous reset puts the body in header phase with delimiter_length 4
// a waiting output transaction holds the sequencer only when a new result must load
`timescale 1ns / 1ps
`default_nettype none
module multipart_part_body_extractor_core import mpbe_pkg::*; #(
	parameter int MAX_DELIMITER = 96,
	parameter int HEADER_CAP    = 512
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [IDX_W-1:0]   table_index,
	input  wire logic [BYTE_W-1:0]  byte_value,
	input  wire logic               last_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    result_kind,
	output logic [BYTE_W-1:0]       payload_byte,
	output logic [1:0]              finish_status,
	output logic                    delimiter_found,
	output logic [TOTAL_W-1:0]      payload_total,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CFG_W-1:0]   delimiter_length
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	mpbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mpbe_dp #(
		.MAX_DELIMITER (MAX_DELIMITER),
		.HEADER_CAP    (HEADER_CAP)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.kind             (kind),
		.table_index      (table_index),
		.byte_value       (byte_value),
		.last_byte        (last_byte),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.delimiter_length (delimiter_length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.payload_byte     (payload_byte),
		.finish_status    (finish_status),
		.delimiter_found  (delimiter_found),
		.payload_total    (payload_total),
		.cmd              (cmd),
		.status           (status)
	);

endmodule
`default_nettype wire
